@@ rtl/fpl_pkg.sv @@
`default_nettype none
package fpl_pkg;

   localparam int EXP_STEPS = 22;

   typedef logic [31:0] fac_table_type [EXP_STEPS];

   // exp(-2^(k-16)) in Q0.32, each factor the rounded square of the one before
   function automatic fac_table_type exp_factors();
      fac_table_type tbl;
      logic [63:0]   f;
      f = 64'hFFFF0000;
      for (int k = 0; k < EXP_STEPS; k++) begin
         tbl[k] = f[31:0];
         f      = (f * f + 64'h80000000) >> 32;
      end
      return tbl;
   endfunction

   localparam fac_table_type EXP_FACTOR = exp_factors();

   localparam logic DR_DIV  = 1'b0;
   localparam logic DR_ROOT = 1'b1;

   localparam logic [7:0] CSR_ALPHA = 8'd0;
   localparam logic [7:0] CSR_BETA  = 8'd1;
   localparam logic [7:0] CSR_L1    = 8'd2;
   localparam logic [7:0] CSR_L2    = 8'd3;

   typedef struct packed {
      logic        start;
      logic        mode;
      logic [63:0] num;
      logic [47:0] den;
   } dr_req_type;

   typedef struct packed {
      logic rd;
      logic wr_n;
      logic wr_z;
      logic wr_w;
   } st_ctl_type;

endpackage
`default_nettype wire

@@ rtl/fpl_if.sv @@
`default_nettype none
interface fpl_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [15:0]        feature_index;
   logic signed [23:0] feature_value;
   logic               last_element;
   logic [16:0]        prediction;
   logic               label;
   modport source (output valid, operation, feature_index, feature_value, last_element,
                   prediction, label, input ready);
   modport sink (input valid, operation, feature_index, feature_value, last_element,
                 prediction, label, output ready);
endinterface

interface fpl_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] probability;
   modport source (output valid, probability, input ready);
   modport sink (input valid, probability, output ready);
endinterface

interface fpl_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/ftrl_proximal_learner_unit.sv @@
// FTRL-Proximal logistic learner over a feature store.
// req_port carries one sparse element a word: operation (predict or update),
// feature index and value, last flag, and for updates a prediction and label.
// rsp_port returns one probability word after a predict element with the last
// flag set; every other element gives no word.
// csr_port writes alpha, beta, l1 and l2 by index; write only while idle.
// One element at a time; the last predict element adds the sigmoid steps
// and one division. Divisions and square roots run on the shared
// shift-subtract unit, and the index reduction is a reciprocal multiply, a
// multiply back by the store depth and one correction; a single shared
// multiplier handles every product.
// After reset the three feature stores are swept to zero, one entry a cycle,
// all FEATURES entries; req_port is not ready until the sweep ends.
// A finished probability sits in an output register; a stalled receiver only
// blocks the learner when a second probability is ready behind it.
`default_nettype none
module ftrl_proximal_learner_unit import fpl_pkg::*; #(
   parameter int FEATURES = 65536
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fpl_req_if.sink    req_port,
   fpl_rsp_if.source  rsp_port,
   fpl_csr_if.sink    csr_port
);

   localparam int IDX_W = $clog2(FEATURES);

   st_ctl_type       st_ctl;
   logic [IDX_W-1:0] st_addr;
   logic [47:0]      st_n_wdata, st_z_wdata, st_n_rdata, st_z_rdata;
   logic [31:0]      st_w_wdata, st_w_rdata;
   logic             st_ready;
   dr_req_type       dr_req;
   logic             dr_done;
   logic [63:0]      dr_result;

   fpl_core #(.FEATURES(FEATURES), .IDX_W(IDX_W)) u_core (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_port.valid),
      .req_ready         (req_port.ready),
      .req_operation     (req_port.operation),
      .req_feature_index (req_port.feature_index),
      .req_feature_value (req_port.feature_value),
      .req_last_element  (req_port.last_element),
      .req_prediction    (req_port.prediction),
      .req_label         (req_port.label),
      .rsp_valid         (rsp_port.valid),
      .rsp_ready         (rsp_port.ready),
      .rsp_probability   (rsp_port.probability),
      .csr_valid         (csr_port.valid),
      .csr_ready         (csr_port.ready),
      .csr_index         (csr_port.index),
      .csr_data          (csr_port.data),
      .st_ctl            (st_ctl),
      .st_addr           (st_addr),
      .st_n_wdata        (st_n_wdata),
      .st_z_wdata        (st_z_wdata),
      .st_w_wdata        (st_w_wdata),
      .st_n_rdata        (st_n_rdata),
      .st_z_rdata        (st_z_rdata),
      .st_w_rdata        (st_w_rdata),
      .st_ready          (st_ready),
      .dr_req            (dr_req),
      .dr_done           (dr_done),
      .dr_result         (dr_result)
   );

   fpl_store #(.FEATURES(FEATURES), .IDX_W(IDX_W)) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (st_ctl),
      .addr    (st_addr),
      .n_wdata (st_n_wdata),
      .z_wdata (st_z_wdata),
      .w_wdata (st_w_wdata),
      .n_rdata (st_n_rdata),
      .z_rdata (st_z_rdata),
      .w_rdata (st_w_rdata),
      .ready   (st_ready)
   );

   fpl_divroot u_divroot (
      .clock  (clock),
      .reset  (reset),
      .req    (dr_req),
      .done   (dr_done),
      .result (dr_result)
   );

endmodule
`default_nettype wire

@@ rtl/fpl_divroot.sv @@
`default_nettype none
module fpl_divroot import fpl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dr_req_type  req,
   output logic             done,
   output logic [63:0]      result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        mode_ff, mode_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] shift_ff, shift_in;
   logic [47:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [47:0] den_ff, den_in;
   logic [48:0] sub_a, sub_b;
   logic [49:0] sub_d;
   logic        ge;

   // one shared subtractor: divisor trial or root trial
   always_comb begin
      if (mode_ff == DR_DIV) begin
         sub_a = {rem_ff, shift_ff[63]};
         sub_b = {1'b0, den_ff};
      end else begin
         sub_a = {rem_ff[46:0], shift_ff[63:62]};
         sub_b = {quo_ff[46:0], 2'b01};
      end
      sub_d = {1'b0, sub_a} - {1'b0, sub_b};
      ge    = !sub_d[49];
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         mode_in  = req.mode;
         cnt_in   = (req.mode == DR_DIV) ? 7'd63 : 7'd23;
         shift_in = req.num;
         rem_in   = '0;
         quo_in   = '0;
         den_in   = req.den;
      end else if (busy_ff) begin
         rem_in   = ge ? sub_d[47:0] : sub_a[47:0];
         quo_in   = {quo_ff[62:0], ge};
         shift_in = (mode_ff == DR_DIV) ? {shift_ff[62:0], 1'b0} : {shift_ff[61:0], 2'b00};
         cnt_in   = cnt_ff - 7'd1;
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff  <= mode_in;
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
   end

   assign done   = done_ff;
   assign result = quo_ff;

endmodule
`default_nettype wire

@@ rtl/fpl_store.sv @@
`default_nettype none
module fpl_store import fpl_pkg::*; #(
   parameter int FEATURES = 65536,
   parameter int IDX_W    = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire st_ctl_type        ctl,
   input  wire logic [IDX_W-1:0]  addr,
   input  wire logic [47:0]       n_wdata,
   input  wire logic [47:0]       z_wdata,
   input  wire logic [31:0]       w_wdata,
   output logic [47:0]            n_rdata,
   output logic [47:0]            z_rdata,
   output logic [31:0]            w_rdata,
   output logic                   ready
);

   localparam logic [IDX_W:0] LAST = (IDX_W+1)'(FEATURES - 1);

   logic [47:0] n_mem [FEATURES];
   logic [47:0] z_mem [FEATURES];
   logic [31:0] w_mem [FEATURES];

   logic [IDX_W:0]   clr_ff, clr_in;
   logic             clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0] wr_addr;

   always_comb begin
      clr_in      = clr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == LAST) clr_busy_in = 1'b0;
      end
      wr_addr = clr_busy_ff ? clr_ff[IDX_W-1:0] : addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_ff      <= clr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // zero sweep after reset, then normal writes
   always_ff @(posedge clock) begin
      if (clr_busy_ff || ctl.wr_n) n_mem[wr_addr] <= clr_busy_ff ? '0 : n_wdata;
      if (ctl.rd) n_rdata <= n_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff || ctl.wr_z) z_mem[wr_addr] <= clr_busy_ff ? '0 : z_wdata;
      if (ctl.rd) z_rdata <= z_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff || ctl.wr_w) w_mem[wr_addr] <= clr_busy_ff ? '0 : w_wdata;
      if (ctl.rd) w_rdata <= w_mem[addr];
   end

   assign ready = !clr_busy_ff;

endmodule
`default_nettype wire

@@ rtl/fpl_core.sv @@
`default_nettype none
module fpl_core import fpl_pkg::*; #(
   parameter int FEATURES = 65536,
   parameter int IDX_W    = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_operation,
   input  wire logic [15:0]        req_feature_index,
   input  wire logic signed [23:0] req_feature_value,
   input  wire logic               req_last_element,
   input  wire logic [16:0]        req_prediction,
   input  wire logic               req_label,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [16:0]             rsp_probability,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [7:0]         csr_index,
   input  wire logic [23:0]        csr_data,
   output st_ctl_type              st_ctl,
   output logic [IDX_W-1:0]        st_addr,
   output logic [47:0]             st_n_wdata,
   output logic [47:0]             st_z_wdata,
   output logic [31:0]             st_w_wdata,
   input  wire logic [47:0]        st_n_rdata,
   input  wire logic [47:0]        st_z_rdata,
   input  wire logic [31:0]        st_w_rdata,
   input  wire logic               st_ready,
   output dr_req_type              dr_req,
   input  wire logic               dr_done,
   input  wire logic [63:0]        dr_result
);

   localparam logic [31:0] MOD_RECIP = 32'((64'd1 << 32) / 64'(FEATURES));
   localparam logic [24:0] FEAT_W    = 25'(FEATURES);

   localparam logic [5:0] S_IDLE   = 6'd0;
   localparam logic [5:0] S_MOD    = 6'd1;
   localparam logic [5:0] S_RD     = 6'd2;
   localparam logic [5:0] S_LD     = 6'd3;
   localparam logic [5:0] S_P_CHK  = 6'd4;
   localparam logic [5:0] S_P_RW   = 6'd5;
   localparam logic [5:0] S_P_D1   = 6'd6;
   localparam logic [5:0] S_P_D1W  = 6'd7;
   localparam logic [5:0] S_P_D2   = 6'd8;
   localparam logic [5:0] S_P_D2W  = 6'd9;
   localparam logic [5:0] S_P_WR   = 6'd10;
   localparam logic [5:0] S_P_DOT  = 6'd11;
   localparam logic [5:0] S_CLAMP  = 6'd12;
   localparam logic [5:0] S_SBIT   = 6'd13;
   localparam logic [5:0] S_SACC   = 6'd14;
   localparam logic [5:0] S_SDIV   = 6'd15;
   localparam logic [5:0] S_SDW    = 6'd16;
   localparam logic [5:0] S_OUT    = 6'd17;
   localparam logic [5:0] S_U_MUL1 = 6'd18;
   localparam logic [5:0] S_U_G    = 6'd19;
   localparam logic [5:0] S_U_MUL2 = 6'd20;
   localparam logic [5:0] S_U_R1   = 6'd21;
   localparam logic [5:0] S_U_R1W  = 6'd22;
   localparam logic [5:0] S_U_R2   = 6'd23;
   localparam logic [5:0] S_U_R2W  = 6'd24;
   localparam logic [5:0] S_U_SC   = 6'd25;
   localparam logic [5:0] S_U_SCW  = 6'd26;
   localparam logic [5:0] S_U_PL   = 6'd27;
   localparam logic [5:0] S_U_PH   = 6'd28;
   localparam logic [5:0] S_U_PA   = 6'd29;
   localparam logic [5:0] S_U_T    = 6'd30;
   localparam logic [5:0] S_U_Z    = 6'd31;
   localparam logic [5:0] S_MQ     = 6'd32;
   localparam logic [5:0] S_MR     = 6'd33;

   localparam logic signed [49:0] S48_MAX = 50'sd140737488355327;
   localparam logic signed [49:0] S48_MIN = -50'sd140737488355328;
   localparam logic signed [47:0] SUM_LIM = 48'sd2293760;

   function automatic logic [47:0] sat48(input logic signed [49:0] v);
      if (v > S48_MAX) return S48_MAX[47:0];
      if (v < S48_MIN) return S48_MIN[47:0];
      return v[47:0];
   endfunction

   logic [5:0]         state_ff, state_in;
   logic               op_ff, op_in;
   logic signed [23:0] xv_ff, xv_in;
   logic               last_ff, last_in;
   logic [16:0]        pr_ff, pr_in;
   logic               lab_ff, lab_in;
   logic [15:0]        fidx_ff, fidx_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [47:0]        n_ff, n_in;
   logic signed [47:0] z_ff, z_in;
   logic signed [31:0] w_ff, w_in;
   logic [47:0]        m_ff, m_in;
   logic [23:0]        r1_ff, r1_in;
   logic [47:0]        den_ff, den_in;
   logic signed [24:0] grad_ff, grad_in;
   logic [47:0]        nn_ff, nn_in;
   logic [23:0]        rn_ff, rn_in;
   logic [40:0]        scale_ff, scale_in;
   logic [72:0]        p_ff, p_in;
   logic signed [49:0] term_ff, term_in;
   logic signed [47:0] dot_ff, dot_in;
   logic [32:0]        acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic [21:0]        t_ff, t_in;
   logic [16:0]        prob_ff, prob_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [16:0]        out_ff, out_in;
   logic [23:0]        alpha_ff, alpha_in;
   logic [23:0]        beta_ff, beta_in;
   logic [23:0]        l1_ff, l1_in;
   logic [23:0]        l2_ff, l2_in;
   logic signed [65:0] prod_ff, prod_in;

   logic signed [32:0] mul_a, mul_b;
   logic [24:0]        mod_r;
   logic [24:0]        mod_fix;
   logic [47:0]        z_mag;
   logic [47:0]        alpha_eff;
   logic [16:0]        pr_sat;
   logic signed [17:0] diff;
   logic [48:0]        nn_sum;
   logic [47:0]        nn_sat;
   logic [31:0]        wm;
   logic signed [49:0] dot_sum;
   logic signed [47:0] dot_clamp;
   logic [47:0]        dot_mag;
   logic [31:0]        wq;
   logic [64:0]        sacc;
   logic [33:0]        sig_den;
   logic [16:0]        q17;
   logic [62:0]        p_round;
   logic signed [49:0] z_sum;
   logic [47:0]        z_new;
   logic [31:0]        fac_sel;
   logic [24:0]        bsum;

   always_comb begin
      // quotient estimate is exact or one low; one subtract fixes it
      mod_r     = {9'd0, fidx_ff} - prod_ff[24:0];
      mod_fix   = (mod_r >= FEAT_W) ? mod_r - FEAT_W : mod_r;
      z_mag     = z_ff[47] ? 48'(-z_ff) : 48'(z_ff);
      alpha_eff = (alpha_ff == '0) ? 48'd1 : {24'd0, alpha_ff};
      pr_sat    = (pr_ff > 17'd65536) ? 17'd65536 : pr_ff;
      diff      = $signed({1'b0, pr_sat}) - (lab_ff ? 18'sd65536 : 18'sd0);
      nn_sum    = {1'b0, n_ff} + {1'b0, prod_ff[47:0]};
      nn_sat    = nn_sum[48] ? '1 : nn_sum[47:0];
      wm        = w_ff[31] ? 32'(-w_ff) : 32'(w_ff);
      dot_sum   = 50'(dot_ff) + 50'($signed(prod_ff[55:16]));
      if (dot_ff > SUM_LIM) dot_clamp = SUM_LIM;
      else if (dot_ff < -SUM_LIM) dot_clamp = -SUM_LIM;
      else dot_clamp = dot_ff;
      dot_mag   = dot_clamp[47] ? 48'(-dot_clamp) : 48'(dot_clamp);
      // weight takes the sign opposite to z
      if (z_ff[47]) wq = (dr_result > 64'h7FFFFFFF) ? 32'h7FFFFFFF : dr_result[31:0];
      else wq = (dr_result >= 64'h80000000) ? 32'h80000000 : 32'(-dr_result[31:0]);
      sacc      = {1'b0, prod_ff[63:0]} + 65'h80000000;
      sig_den   = 34'h100000000 + {1'b0, acc_ff};
      q17       = dr_result[16:0];
      p_round   = {1'b0, p_ff[61:0]} + 63'd65535;
      z_sum     = 50'(z_ff) + 50'(grad_ff) - term_ff;
      z_new     = sat48(z_sum);
      fac_sel   = (cnt_ff < 5'(EXP_STEPS)) ? EXP_FACTOR[cnt_ff] : '0;
      bsum      = {1'b0, beta_ff} + {1'b0, r1_ff};
   end

   always_comb begin
      unique case (state_ff)
         S_MOD: begin
            mul_a = $signed({17'd0, fidx_ff});
            mul_b = $signed({1'b0, MOD_RECIP});
         end
         S_MQ: begin
            mul_a = $signed({17'd0, prod_ff[47:32]});
            mul_b = $signed({8'd0, FEAT_W});
         end
         S_P_WR: begin
            mul_a = 33'(w_ff);
            mul_b = 33'(xv_ff);
         end
         S_U_MUL1: begin
            mul_a = 33'(diff);
            mul_b = 33'(xv_ff);
         end
         S_U_MUL2: begin
            mul_a = 33'(grad_ff);
            mul_b = 33'(grad_ff);
         end
         S_U_PL: begin
            mul_a = $signed({1'b0, scale_ff[31:0]});
            mul_b = $signed({1'b0, wm});
         end
         S_U_PH: begin
            mul_a = $signed({24'd0, scale_ff[40:32]});
            mul_b = $signed({1'b0, wm});
         end
         S_SBIT: begin
            mul_a = $signed({1'b0, acc_ff[31:0]});
            mul_b = $signed({1'b0, fac_sel});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      xv_in        = xv_ff;
      last_in      = last_ff;
      pr_in        = pr_ff;
      lab_in       = lab_ff;
      fidx_in      = fidx_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      z_in         = z_ff;
      w_in         = w_ff;
      m_in         = m_ff;
      r1_in        = r1_ff;
      den_in       = den_ff;
      grad_in      = grad_ff;
      nn_in        = nn_ff;
      rn_in        = rn_ff;
      scale_in     = scale_ff;
      p_in         = p_ff;
      term_in      = term_ff;
      dot_in       = dot_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      t_in         = t_ff;
      prob_in      = prob_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      alpha_in     = alpha_ff;
      beta_in      = beta_ff;
      l1_in        = l1_ff;
      l2_in        = l2_ff;
      req_ready    = (state_ff == S_IDLE) && st_ready;
      st_ctl       = '0;
      st_addr      = idx_ff;
      st_n_wdata   = nn_ff;
      st_z_wdata   = z_new;
      st_w_wdata   = w_ff;
      dr_req       = '0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_ALPHA: alpha_in = csr_data;
            CSR_BETA:  beta_in  = csr_data;
            CSR_L1:    l1_in    = csr_data;
            CSR_L2:    l2_in    = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in    = req_operation;
               xv_in    = req_feature_value;
               last_in  = req_last_element;
               pr_in    = req_prediction;
               lab_in   = req_label;
               fidx_in  = req_feature_index;
               idx_in   = '0;
               cnt_in   = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            // reduce the index modulo the store depth by a reciprocal multiply
            state_in = S_MQ;
         end
         S_MQ: begin
            state_in = S_MR;
         end
         S_MR: begin
            idx_in   = IDX_W'(mod_fix);
            state_in = S_RD;
         end
         S_RD: begin
            st_ctl.rd = 1'b1;
            state_in  = S_LD;
         end
         S_LD: begin
            n_in     = st_n_rdata;
            z_in     = st_z_rdata;
            w_in     = st_w_rdata;
            state_in = op_ff ? S_U_MUL1 : S_P_CHK;
         end
         S_P_CHK: begin
            if (z_mag <= {24'd0, l1_ff}) begin
               w_in     = '0;
               state_in = S_P_WR;
            end else begin
               m_in         = z_mag - {24'd0, l1_ff};
               dr_req.start = 1'b1;
               dr_req.mode  = DR_ROOT;
               dr_req.num   = {n_ff, 16'd0};
               state_in     = S_P_RW;
            end
         end
         S_P_RW: begin
            if (dr_done) begin
               r1_in    = dr_result[23:0];
               state_in = S_P_D1;
            end
         end
         S_P_D1: begin
            dr_req.start = 1'b1;
            dr_req.mode  = DR_DIV;
            dr_req.num   = {23'd0, bsum, 16'd0};
            dr_req.den   = alpha_eff;
            state_in     = S_P_D1W;
         end
         S_P_D1W: begin
            if (dr_done) begin
               den_in   = dr_result[47:0] + {24'd0, l2_ff};
               state_in = S_P_D2;
            end
         end
         S_P_D2: begin
            dr_req.start = 1'b1;
            dr_req.mode  = DR_DIV;
            dr_req.num   = {m_ff, 16'd0};
            dr_req.den   = den_ff;
            state_in     = S_P_D2W;
         end
         S_P_D2W: begin
            if (dr_done) begin
               w_in     = wq;
               state_in = S_P_WR;
            end
         end
         S_P_WR: begin
            st_ctl.wr_w = 1'b1;
            state_in    = S_P_DOT;
         end
         S_P_DOT: begin
            dot_in   = sat48(dot_sum);
            state_in = last_ff ? S_CLAMP : S_IDLE;
         end
         S_CLAMP: begin
            neg_in   = dot_ff[47];
            t_in     = dot_mag[21:0];
            acc_in   = 33'h100000000;
            cnt_in   = '0;
            dot_in   = '0;
            state_in = S_SBIT;
         end
         S_SBIT: begin
            if (cnt_ff == 5'(EXP_STEPS) || t_ff == '0) begin
               state_in = S_SDIV;
            end else if (t_ff[0] && !acc_ff[32]) begin
               state_in = S_SACC;
            end else begin
               if (t_ff[0]) acc_in = {1'b0, fac_sel};
               t_in   = t_ff >> 1;
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_SACC: begin
            acc_in   = sacc[64:32];
            t_in     = t_ff >> 1;
            cnt_in   = cnt_ff + 5'd1;
            state_in = S_SBIT;
         end
         S_SDIV: begin
            dr_req.start = 1'b1;
            dr_req.mode  = DR_DIV;
            dr_req.num   = 64'h1000000000000 + {31'd0, sig_den[33:1]};
            dr_req.den   = {14'd0, sig_den};
            state_in     = S_SDW;
         end
         S_SDW: begin
            if (dr_done) begin
               prob_in  = neg_ff ? 17'd65536 - q17 : q17;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_in       = prob_ff;
               state_in     = S_IDLE;
            end
         end
         S_U_MUL1: begin
            state_in = S_U_G;
         end
         S_U_G: begin
            grad_in  = prod_ff[40:16];
            state_in = S_U_MUL2;
         end
         S_U_MUL2: begin
            state_in = S_U_R1;
         end
         S_U_R1: begin
            nn_in        = nn_sat;
            dr_req.start = 1'b1;
            dr_req.mode  = DR_ROOT;
            dr_req.num   = {nn_sat, 16'd0};
            state_in     = S_U_R1W;
         end
         S_U_R1W: begin
            if (dr_done) begin
               rn_in    = dr_result[23:0];
               state_in = S_U_R2;
            end
         end
         S_U_R2: begin
            dr_req.start = 1'b1;
            dr_req.mode  = DR_ROOT;
            dr_req.num   = {n_ff, 16'd0};
            state_in     = S_U_R2W;
         end
         S_U_R2W: begin
            if (dr_done) begin
               r1_in    = dr_result[23:0];
               state_in = S_U_SC;
            end
         end
         S_U_SC: begin
            dr_req.start = 1'b1;
            dr_req.mode  = DR_DIV;
            dr_req.num   = {24'd0, rn_ff - r1_ff, 16'd0};
            dr_req.den   = alpha_eff;
            state_in     = S_U_SCW;
         end
         S_U_SCW: begin
            if (dr_done) begin
               scale_in = dr_result[40:0];
               state_in = S_U_PL;
            end
         end
         S_U_PL: begin
            state_in = S_U_PH;
         end
         S_U_PH: begin
            p_in     = {9'd0, prod_ff[63:0]};
            state_in = S_U_PA;
         end
         S_U_PA: begin
            p_in     = p_ff + {prod_ff[40:0], 32'd0};
            state_in = S_U_T;
         end
         S_U_T: begin
            if (|p_ff[72:62]) term_in = w_ff[31] ? -50'sh1000000000000 : 50'sh1000000000000;
            else if (!w_ff[31]) term_in = $signed({4'd0, p_ff[61:16]});
            else term_in = -$signed({3'd0, p_round[62:16]});
            state_in = S_U_Z;
         end
         S_U_Z: begin
            st_ctl.wr_z = 1'b1;
            st_ctl.wr_n = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         dot_ff       <= '0;
         alpha_ff     <= 24'd6554;
         beta_ff      <= 24'd65536;
         l1_ff        <= 24'd65536;
         l2_ff        <= 24'd65536;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dot_ff       <= dot_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
         l1_ff        <= l1_in;
         l2_ff        <= l2_in;
      end
      op_ff    <= op_in;
      xv_ff    <= xv_in;
      last_ff  <= last_in;
      pr_ff    <= pr_in;
      lab_ff   <= lab_in;
      fidx_ff  <= fidx_in;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      n_ff     <= n_in;
      z_ff     <= z_in;
      w_ff     <= w_in;
      m_ff     <= m_in;
      r1_ff    <= r1_in;
      den_ff   <= den_in;
      grad_ff  <= grad_in;
      nn_ff    <= nn_in;
      rn_ff    <= rn_in;
      scale_ff <= scale_in;
      p_ff     <= p_in;
      term_ff  <= term_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
      t_ff     <= t_in;
      prob_ff  <= prob_in;
      out_ff   <= out_in;
      prod_ff  <= prod_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_probability = out_ff;
   assign csr_ready       = 1'b1;

endmodule
`default_nettype wire

@@ bench/ftrl_proximal_learner_unit_tb.sv @@
`timescale 1ns / 100ps
module ftrl_proximal_learner_unit_tb;
   import fpl_pkg::*;

   localparam int          NFEAT      = 65536;
   localparam longint      S48_HI     = 64'sh00007FFFFFFFFFFF;
   localparam longint      S48_LO     = -64'sh0000800000000000;
   localparam longint      SUM_CLAMP  = 64'sd35 * 64'sd65536;
   localparam int          DRAIN_WAIT = 400;
   localparam longint      CYCLE_CAP  = 64'd4000000;
   localparam logic        OP_PREDICT = 1'b0;
   localparam logic        OP_UPDATE  = 1'b1;

   logic clock;
   logic reset;

   fpl_req_if req_bus ();
   fpl_rsp_if rsp_bus ();
   fpl_csr_if csr_bus ();

   ftrl_proximal_learner_unit #(.FEATURES(NFEAT)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // learner state as predicted
   longint unsigned sq_grad [NFEAT];
   longint          z_acc [NFEAT];
   int              w_last [NFEAT];
   longint          run_sum;
   logic [23:0]     lr_alpha, lr_beta, reg_l1, reg_l2;

   logic [16:0] prob_queue [$];
   int          fail_count;
   longint      cycle_count = 0;
   int          idle_pct;
   int          stall_pct;
   int          item_count;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cycle_count);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (prob_queue.size() == 0) begin
            report_mismatch("unexpected probability word", -1, rsp_bus.probability);
         end else begin
            logic [16:0] want;
            want = prob_queue.pop_front();
            if (rsp_bus.probability !== want)
               report_mismatch("probability", want, rsp_bus.probability);
         end
      end
   end

   function automatic longint unsigned isqrt48(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 46;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint sat48(input longint v);
      if (v > S48_HI) return S48_HI;
      if (v < S48_LO) return S48_LO;
      return v;
   endfunction

   function automatic longint unsigned alpha_used();
      return (lr_alpha == 0) ? 64'd1 : {40'd0, lr_alpha};
   endfunction

   function automatic int feature_weight(input int idx);
      longint          z;
      longint unsigned mag, m, den, q;
      z   = z_acc[idx];
      mag = (z < 0) ? longint'(-z) : longint'(z);
      if (mag <= reg_l1) return 0;
      m   = mag - reg_l1;
      den = ((longint'(lr_beta) + isqrt48(sq_grad[idx])) << 16) / alpha_used() + reg_l2;
      q   = (den != 0) ? (m << 16) / den : 64'hFFFFFFFFFFFFFFFF;
      if (z < 0) return (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : int'(q);
      if (q >= 64'h80000000) return 32'h80000000;
      return -int'(q);
   endfunction

   task automatic apply_gradient(input int idx, input longint xv, input logic [16:0] pred,
                                 input logic lab);
      longint          diff, grad, term, wv;
      longint unsigned pr, g2, n_old, n_new, scale, wm;
      wv    = w_last[idx];
      pr    = (pred > 17'd65536) ? 64'd65536 : {47'd0, pred};
      diff  = longint'(pr) - (lab ? 64'sd65536 : 64'sd0);
      grad  = (diff * xv) >>> 16;
      g2    = grad * grad;
      n_old = sq_grad[idx];
      n_new = n_old + g2;
      if (n_new > 64'hFFFFFFFFFFFF) n_new = 64'hFFFFFFFFFFFF;
      scale = ((isqrt48(n_new) - isqrt48(n_old)) << 16) / alpha_used();
      wm    = (wv < 0) ? -wv : wv;
      if (wm != 0 && scale > ((64'd1 << 62) - 1) / wm)
         term = (wv > 0) ? (64'sd1 <<< 48) : -(64'sd1 <<< 48);
      else
         term = (longint'(scale) * wv) >>> 16;
      z_acc[idx]   = sat48(z_acc[idx] + grad - term);
      sq_grad[idx] = n_new;
   endtask

   function automatic logic [16:0] sigmoid_q16(input longint s);
      longint unsigned t, acc, fac, den, q;
      if (s > SUM_CLAMP) s = SUM_CLAMP;
      if (s < -SUM_CLAMP) s = -SUM_CLAMP;
      t   = (s < 0) ? -s : s;
      acc = 64'd1 << 32;
      fac = 64'hFFFF0000;
      for (int k = 0; k < 22; k++) begin
         if (t[k]) acc = (acc * fac + (64'd1 << 31)) >> 32;
         fac = (fac * fac + (64'd1 << 31)) >> 32;
      end
      den = (64'd1 << 32) + acc;
      q   = ((64'd1 << 48) + den / 2) / den;
      return (s < 0) ? 17'(65536 - q) : 17'(q);
   endfunction

   task automatic predict_element(input logic op, input logic [15:0] idx,
                                  input logic [23:0] val, input logic last,
                                  input logic [16:0] pred, input logic lab);
      longint xv;
      int     wv;
      xv = longint'($signed(val));
      if (op == OP_UPDATE) begin
         apply_gradient(idx, xv, pred, lab);
      end else begin
         wv = feature_weight(idx);
         w_last[idx] = wv;
         run_sum = sat48(run_sum + ((longint'(wv) * xv) >>> 16));
         if (last) begin
            prob_queue.push_back(sigmoid_q16(run_sum));
            run_sum = 0;
         end
      end
   endtask

   task automatic send_element(input logic op, input logic [15:0] idx, input logic [23:0] val,
                               input logic last, input logic [16:0] pred, input logic lab);
      int gap;
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= op;
      req_bus.feature_index <= idx;
      req_bus.feature_value <= val;
      req_bus.last_element  <= last;
      req_bus.prediction    <= pred;
      req_bus.label         <= lab;
      do @(posedge clock); while (!req_bus.ready);
      predict_element(op, idx, val, last, pred, lab);
      item_count++;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 50) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (prob_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [7:0] idx, input logic [23:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_ALPHA: lr_alpha = data;
         CSR_BETA:  lr_beta  = data;
         CSR_L1:    reg_l1   = data;
         CSR_L2:    reg_l2   = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [23:0] a, input logic [23:0] b,
                                input logic [23:0] l1, input logic [23:0] l2);
      write_csr(CSR_ALPHA, a);
      write_csr(CSR_BETA, b);
      write_csr(CSR_L1, l1);
      write_csr(CSR_L2, l2);
   endtask

   task automatic test_directed();
      idle_pct  = 0;
      stall_pct = 0;
      // empty sum and extreme values under the reset settings
      send_element(OP_PREDICT, 16'd0, 24'h7FFFFF, 1'b1, 17'd0, 1'b0);
      send_element(OP_UPDATE, 16'd0, 24'h7FFFFF, 1'b0, 17'd65536, 1'b0);
      send_element(OP_UPDATE, 16'hFFFF, 24'h800000, 1'b1, 17'h1FFFF, 1'b0);
      send_element(OP_UPDATE, 16'd0, 24'h800000, 1'b0, 17'd0, 1'b1);
      send_element(OP_PREDICT, 16'd0, 24'h7FFFFF, 1'b0, 17'd0, 1'b0);
      send_element(OP_PREDICT, 16'hFFFF, 24'h800000, 1'b1, 17'd0, 1'b0);
      // hold the sender until every word is back
      drain_results();
      // zero denominator saturates the weight, big sums hit the clamp
      load_settings(24'hFFFFFF, 24'd0, 24'd0, 24'd0);
      send_element(OP_PREDICT, 16'd0, 24'h7FFFFF, 1'b0, 17'd0, 1'b0);
      send_element(OP_PREDICT, 16'd0, 24'h7FFFFF, 1'b0, 17'd0, 1'b0);
      send_element(OP_PREDICT, 16'hFFFF, 24'h7FFFFF, 1'b1, 17'd0, 1'b0);
      send_element(OP_PREDICT, 16'd0, 24'h800000, 1'b1, 17'd0, 1'b0);
      send_element(OP_UPDATE, 16'd0, 24'h7FFFFF, 1'b0, 17'd0, 1'b1);
      send_element(OP_PREDICT, 16'd0, 24'h010000, 1'b1, 17'd0, 1'b0);
      drain_results();
      // zero alpha acts as the smallest step
      load_settings(24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_element(OP_UPDATE, 16'd7, 24'h7FFFFF, 1'b0, 17'd65536, 1'b0);
      send_element(OP_PREDICT, 16'd7, 24'h7FFFFF, 1'b1, 17'd0, 1'b0);
      send_element(OP_UPDATE, 16'd7, 24'h800000, 1'b0, 17'd0, 1'b1);
      send_element(OP_PREDICT, 16'd7, 24'h000001, 1'b1, 17'd0, 1'b0);
      drain_results();
      load_settings(24'd1, 24'd0, 24'd0, 24'd0);
      send_element(OP_UPDATE, 16'd9, 24'h7FFFFF, 1'b0, 17'd65536, 1'b0);
      send_element(OP_PREDICT, 16'd9, 24'hFFFFFF, 1'b1, 17'd0, 1'b0);
      drain_results();
   endtask

   task automatic random_settings();
      logic [23:0] a, b, l1, l2;
      a  = 24'((($urandom_range(3) == 0) ? $urandom : $urandom_range(32767, 1)) & 24'hFFFFFF);
      b  = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(131072));
      l1 = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(16384));
      l2 = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(131072));
      load_settings(a, b, l1, l2);
   endtask

   function automatic logic [15:0] pick_index();
      if ($urandom_range(9) == 0) return 16'($urandom);
      return 16'($urandom_range(15));
   endfunction

   function automatic logic [23:0] pick_value();
      if ($urandom_range(3) == 0) return 24'($urandom);
      return 24'($signed($urandom_range(524288)) - 262144);
   endfunction

   function automatic logic [16:0] pick_prediction();
      if ($urandom_range(7) == 0) return 17'($urandom);
      return 17'($urandom_range(65536));
   endfunction

   task automatic test_random(input int target, input int idle, input int stall);
      logic [15:0] idx_list [4];
      int          elems, start;
      logic        lab;
      idle_pct  = idle;
      stall_pct = stall;
      start     = item_count;
      while (item_count - start < target) begin
         if ($urandom_range(9) < 8) begin
            elems = $urandom_range(4, 1);
            for (int i = 0; i < elems; i++) begin
               idx_list[i] = pick_index();
               send_element(OP_PREDICT, idx_list[i], pick_value(), i == elems - 1,
                            17'($urandom), 1'($urandom));
            end
            lab = 1'($urandom);
            for (int i = 0; i < elems; i++)
               send_element(OP_UPDATE, idx_list[i], pick_value(), 1'($urandom),
                            pick_prediction(), lab);
         end else begin
            send_element(1'($urandom), pick_index(), pick_value(), 1'($urandom),
                         pick_prediction(), 1'($urandom));
         end
      end
      drain_results();
   endtask

   initial begin
      reset      = 1'b1;
      fail_count = 0;
      item_count = 0;
      idle_pct   = 0;
      stall_pct  = 0;
      run_sum    = 0;
      lr_alpha   = 24'd6554;
      lr_beta    = 24'd65536;
      reg_l1     = 24'd65536;
      reg_l2     = 24'd65536;
      for (int i = 0; i < NFEAT; i++) begin
         sq_grad[i] = 0;
         z_acc[i]   = 0;
         w_last[i]  = 0;
      end
      req_bus.valid         <= 1'b0;
      req_bus.operation     <= OP_PREDICT;
      req_bus.feature_index <= '0;
      req_bus.feature_value <= '0;
      req_bus.last_element  <= 1'b0;
      req_bus.prediction    <= '0;
      req_bus.label         <= 1'b0;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= CSR_ALPHA;
      csr_bus.data          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      random_settings();
      test_random(450, 0, 0);
      load_settings(24'd6554, 24'd65536, 24'd65536, 24'd65536);
      test_random(450, 72, 0);
      random_settings();
      test_random(450, 0, 72);
      random_settings();
      test_random(450, 34, 34);

      if (prob_queue.size() != 0)
         report_mismatch("words still expected", 0, prob_queue.size());
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/fpl_pkg.sv
rtl/fpl_if.sv
rtl/fpl_divroot.sv
rtl/fpl_store.sv
rtl/fpl_core.sv
rtl/ftrl_proximal_learner_unit.sv
bench/ftrl_proximal_learner_unit_tb.sv
